// File: rtl/plti_pkg.sv
package plti_pkg;

	// operation codes of an input transaction
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic wr_point;    // write one breakpoint pair from the input ports
		logic cap_value;   // capture the lookup value
		logic cap_prev;    // keep the entry just read as the lower breakpoint
		logic res_from_rd; // result is the y of the entry just read
		logic calc_start;  // form the deltas from the lower and upper breakpoints
		logic mul;         // register the product
		logic div_init;    // load the divider from the product
		logic div_step;    // one restoring division step
		logic res_from_div; // result is lower y plus the signed quotient
		logic load_out;    // move the result into the output register
	} cmd_t;

	// compare flags of the lookup value against the x just read
	typedef struct packed {
		logic le;
		logic ge;
		logic eq;
	} sts_t;

endpackage

// File: rtl/plti_ctrl.sv
module plti_ctrl
	import plti_pkg::*;
#(
	parameter int MAX_POINTS = 8,
	parameter int VALUE_BITS = 16,
	localparam int IW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(VALUE_BITS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          operation,
	output logic          out_valid,
	input  logic          out_ready,
	input  sts_t          sts,
	input  logic [IW-1:0] last_idx,
	output cmd_t          cmd,
	output logic [IW-1:0] rd_addr
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_FIRST,
		S_CHK_FIRST,
		S_CHK_LAST,
		S_SCAN,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	state_t        state_q;
	logic [IW-1:0] p_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          accept;
	logic          scan_go;
	logic          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	// keep walking while below the last entry in use and the value lies above x
	assign scan_go   = (p_q < last_idx) && !sts.le;

	// command decode
	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.wr_point  = accept && (operation == OP_LOAD);
				cmd.cap_value = accept && (operation == OP_LOOKUP);
			end
			S_RD_FIRST: begin
				rd_addr = '0;
			end
			S_CHK_FIRST: begin
				rd_addr         = last_idx;
				cmd.res_from_rd = sts.le;
				cmd.cap_prev    = !sts.le;
			end
			S_CHK_LAST: begin
				rd_addr         = IW'(1);
				cmd.res_from_rd = sts.ge;
			end
			S_SCAN: begin
				rd_addr         = p_q + IW'(1);
				cmd.cap_prev    = scan_go;
				cmd.res_from_rd = !scan_go && sts.eq;
				cmd.calc_start  = !scan_go && !sts.eq;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_FIN: begin
				cmd.res_from_div = 1'b1;
			end
			S_OUT: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			p_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (operation == OP_LOOKUP)) begin
						state_q <= S_RD_FIRST;
					end
				end
				S_RD_FIRST: begin
					state_q <= S_CHK_FIRST;
				end
				S_CHK_FIRST: begin
					state_q <= sts.le ? S_OUT : S_CHK_LAST;
				end
				S_CHK_LAST: begin
					p_q     <= IW'(1);
					state_q <= sts.ge ? S_OUT : S_SCAN;
				end
				S_SCAN: begin
					if (scan_go) begin
						p_q <= p_q + IW'(1);
					end else begin
						state_q <= sts.eq ? S_OUT : S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV_INIT;
				end
				S_DIV_INIT: begin
					cnt_q   <= CW'(VALUE_BITS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/plti_dp.sv
module plti_dp
	import plti_pkg::*;
#(
	parameter int MAX_POINTS = 8,
	parameter int VALUE_BITS = 16,
	localparam int IW = $clog2(MAX_POINTS),
	localparam int VB = VALUE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	input  logic [2:0]           point_index,
	input  logic signed [VB-1:0] point_x,
	input  logic signed [VB-1:0] point_y,
	input  logic signed [VB-1:0] lookup_value,
	input  cmd_t                 cmd,
	input  logic [IW-1:0]        rd_addr,
	output sts_t                 sts,
	output logic [IW-1:0]        last_idx,
	output logic signed [VB-1:0] result_value
);

	// breakpoint memories
	logic signed [VB-1:0] x_mem [MAX_POINTS];
	logic signed [VB-1:0] y_mem [MAX_POINTS];

	logic [IW-1:0]        last_idx_q;
	logic signed [VB-1:0] v_q;
	logic signed [VB-1:0] rd_x_q;
	logic signed [VB-1:0] rd_y_q;
	logic signed [VB-1:0] prev_x_q;
	logic signed [VB-1:0] prev_y_q;
	logic [VB-1:0]        dv_q;
	logic [VB-1:0]        dx_q;
	logic [VB-1:0]        mag_q;
	logic                 neg_q;
	logic [2*VB-1:0]      prod_q;
	logic [VB-1:0]        rem_q;
	logic [VB-1:0]        sh_q;
	logic signed [VB-1:0] res_q;
	logic signed [VB-1:0] out_q;

	logic                 wr_ok;
	logic [IW-1:0]        wr_addr;
	logic [VB:0]          dv_full;
	logic [VB:0]          dx_full;
	logic [VB:0]          dy_full;
	logic [VB:0]          dy_neg;
	logic [VB:0]          rem2;
	logic                 take;
	logic [VB:0]          rem_next;
	logic [VB:0]          q_signed;
	logic [VB:0]          sum_full;

	assign last_idx     = last_idx_q;
	assign result_value = out_q;

	assign wr_ok   = (32'(point_index) < MAX_POINTS);
	assign wr_addr = IW'(point_index);

	// point count register, held as the index of the last entry in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= IW'(MAX_POINTS - 1);
		end else if (cfg_we) begin
			priority if (cfg_wdata == 4'd0) begin
				last_idx_q <= '0;
			end else if (32'(cfg_wdata) > MAX_POINTS) begin
				last_idx_q <= IW'(MAX_POINTS - 1);
			end else begin
				last_idx_q <= IW'(cfg_wdata - 4'd1);
			end
		end
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_point && wr_ok) begin
			x_mem[wr_addr] <= point_x;
			y_mem[wr_addr] <= point_y;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	// compares against the entry just read
	assign sts.le = (v_q <= rd_x_q);
	assign sts.ge = (v_q >= rd_x_q);
	assign sts.eq = (v_q == rd_x_q);

	// deltas; the bracket guarantees prev_x < v < x
	assign dv_full = {v_q[VB-1], v_q} - {prev_x_q[VB-1], prev_x_q};
	assign dx_full = {rd_x_q[VB-1], rd_x_q} - {prev_x_q[VB-1], prev_x_q};
	assign dy_full = {rd_y_q[VB-1], rd_y_q} - {prev_y_q[VB-1], prev_y_q};
	assign dy_neg  = -dy_full;

	// restoring division step, quotient bits shift in as dividend bits leave
	assign rem2     = {rem_q, sh_q[VB-1]};
	assign take     = (rem2 >= {1'b0, dx_q});
	assign rem_next = take ? (rem2 - {1'b0, dx_q}) : rem2;

	// signed quotient added to the lower y
	assign q_signed = neg_q ? -{1'b0, sh_q} : {1'b0, sh_q};
	assign sum_full = {prev_y_q[VB-1], prev_y_q} + q_signed;

	// lookup datapath registers
	always_ff @(posedge clk) begin
		if (cmd.cap_value) begin
			v_q <= lookup_value;
		end
		if (cmd.cap_prev) begin
			prev_x_q <= rd_x_q;
			prev_y_q <= rd_y_q;
		end
		if (cmd.calc_start) begin
			dv_q  <= dv_full[VB-1:0];
			dx_q  <= dx_full[VB-1:0];
			neg_q <= dy_full[VB];
			mag_q <= dy_full[VB] ? dy_neg[VB-1:0] : dy_full[VB-1:0];
		end
		if (cmd.mul) begin
			prod_q <= {{VB{1'b0}}, dv_q} * {{VB{1'b0}}, mag_q};
		end
		if (cmd.div_init) begin
			rem_q <= prod_q[2*VB-1:VB];
			sh_q  <= prod_q[VB-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_next[VB-1:0];
			sh_q  <= {sh_q[VB-2:0], take};
		end
		if (cmd.res_from_rd) begin
			res_q <= rd_y_q;
		end else if (cmd.res_from_div) begin
			res_q <= sum_full[VB-1:0];
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

endmodule

// File: rtl/piecewise_linear_table_interpolator_unit.sv
// Piecewise-linear table interpolator. A load transaction (operation 0) writes one
// x/y breakpoint pair and gives no result; the block stays ready, so loads can follow
// each other back to back. A lookup transaction (operation 1) returns one y:
// clamped to the first or last y outside the table, the breakpoint y on an exact
// hit, otherwise linear interpolation with the quotient truncated toward zero.
// No new transaction is taken while a lookup is in progress. A lookup first checks
// the first and then the last entry, then walks the table upward one table read per
// cycle through the single read port to find the bracketing pair, which is the
// whole cost of an exact hit; an interpolation adds a registered multiply and the
// one-bit-per-cycle restoring divider.
// The result is presented as the block turns ready again; a lookup also waits in
// its last cycle while the previous result is still held in the output register.
// Breakpoints must be loaded before they are used; x values are expected in
// non-decreasing order. point_count may only be written while the block is idle.
// The output register lets the next transaction be taken while a result waits.
module piecewise_linear_table_interpolator_unit
	import plti_pkg::*;
#(
	parameter int MAX_POINTS = 8,
	parameter int VALUE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [3:0]                   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [2:0]                   point_index,
	input  logic signed [VALUE_BITS-1:0] point_x,
	input  logic signed [VALUE_BITS-1:0] point_y,
	input  logic signed [VALUE_BITS-1:0] lookup_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS-1:0] result_value
);

	localparam int IW = $clog2(MAX_POINTS);

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] last_idx;

	// sequencer
	plti_ctrl #(
		.MAX_POINTS(MAX_POINTS),
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.last_idx  (last_idx),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	// table, arithmetic and output register
	plti_dp #(
		.MAX_POINTS(MAX_POINTS),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.lookup_value (lookup_value),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.sts          (sts),
		.last_idx     (last_idx),
		.result_value (result_value)
	);

endmodule
